/* hdl/handshake_bit_link_master_top_defines.svh */
// Assertion macros shared by the bit link master RTL.
`ifndef HANDSHAKE_BIT_LINK_MASTER_TOP_DEFINES_SVH
`define HANDSHAKE_BIT_LINK_MASTER_TOP_DEFINES_SVH

// Implication checked on every rising edge of clk, masked while rst_n is low.
`define HBLM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, same clocking and reset masking.
`define HBLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hblm_pkg.sv */
// Package: shared types and constants of the bit link master.
`timescale 1ns / 1ps
`default_nettype none

package hblm_pkg;

    localparam int SEND_WIDTH = 8;
    localparam int RECV_WIDTH = 16;
    localparam int POS_WIDTH  = $clog2(RECV_WIDTH);

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_SAMPLE = 2'd0;
    localparam mode_t MODE_SEND   = 2'd1;
    localparam mode_t MODE_RECV   = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_SEND_HI = 5'b00010,
        PH_SEND_LO = 5'b00100,
        PH_RECV_HI = 5'b01000,
        PH_RECV_LO = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        drive_clock;
        logic        drive_data;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [15:0] received_value;
    } result_t;

endpackage

`default_nettype wire

/* hdl/hblm_if.sv */
// Interfaces: command and result channels of the bit link master.
`timescale 1ns / 1ps
`default_nettype none

interface hblm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] send_data;
    logic [4:0] bit_count;
    logic       peer_clock;
    logic       peer_data;
    logic       tick;

    modport source (output valid, mode, send_data, bit_count, peer_clock, peer_data, tick,
                    input ready);
    modport sink   (input valid, mode, send_data, bit_count, peer_clock, peer_data, tick,
                    output ready);
endinterface

interface hblm_res_if;
    logic        valid;
    logic        ready;
    logic        drive_clock;
    logic        drive_data;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] received_value;

    modport source (output valid, drive_clock, drive_data, busy_res, done_res, timed_out,
                    received_value, input ready);
    modport sink   (input valid, drive_clock, drive_data, busy_res, done_res, timed_out,
                    received_value, output ready);
endinterface

`default_nettype wire

/* hdl/handshake_bit_link_master_top.sv */
// Top level: handshaked bit link master, one result per command transfer.
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake      payload
//  cmd       in   valid/ready    mode, send_data, bit_count, peer_clock, peer_data, tick
//  res       out  valid/ready    drive_clock, drive_data, busy_res, done_res,
//                                timed_out, received_value
//  cfg_wr    in   cfg_wr_en      cfg_wr_data -> timeout_ticks (no read-back)
//
// Each command transfer is handled combinationally: the phase logic reads the
// live command and state, and the result lands in the output register.
// Sustained rate is one transfer per clock; cmd.ready only drops while a
// result sits in the output register and res.ready is low.
// rst_n is asynchronous, active low: phase idle, counters clear, timeout 1000.

`include "handshake_bit_link_master_top_defines.svh"

module handshake_bit_link_master_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    hblm_cmd_if.sink         cmd,
    hblm_res_if.source       res
);
    import hblm_pkg::*;

    // Handshake state
    phase_t                  phase_reg, phase_next;
    logic [SEND_WIDTH-1:0]   send_shift_reg, send_shift_next;
    logic [4:0]              bits_left_reg, bits_left_next;
    logic [RECV_WIDTH-1:0]   receive_acc_reg, receive_acc_next;
    logic [POS_WIDTH-1:0]    bit_position_reg, bit_position_next;
    logic                    sampled_bit_reg, sampled_bit_next;
    logic [31:0]             elapsed_reg, elapsed_next;
    logic [31:0]             timeout_reg;

    // Output register
    logic                    out_valid_reg;
    result_t                 out_data_reg;
    result_t                 result_next;

    logic                    cmd_fire;
    logic                    advanced;
    logic                    done;
    logic                    tmo;
    logic [4:0]              recv_count;

    assign cmd.ready = !out_valid_reg || res.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Receive count saturates at the accumulator width
    assign recv_count = (32'(cmd.bit_count) > RECV_WIDTH) ? 5'(RECV_WIDTH) : cmd.bit_count;

    always_comb
    begin
        phase_next        = phase_reg;
        send_shift_next   = send_shift_reg;
        bits_left_next    = bits_left_reg;
        receive_acc_next  = receive_acc_reg;
        bit_position_next = bit_position_reg;
        sampled_bit_next  = sampled_bit_reg;
        elapsed_next      = elapsed_reg;
        advanced          = 1'b0;
        done              = 1'b0;
        tmo               = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            // Start: only send and receive codes; anything else is a sample
            if (cmd.mode == MODE_SEND)
            begin
                elapsed_next    = '0;
                send_shift_next = SEND_WIDTH'(cmd.send_data);
                bits_left_next  = cmd.bit_count;
                phase_next      = PH_SEND_HI;
                if (cmd.bit_count == 5'd0)
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end
            else if (cmd.mode == MODE_RECV)
            begin
                elapsed_next      = '0;
                receive_acc_next  = '0;
                bit_position_next = '0;
                sampled_bit_next  = 1'b0;
                bits_left_next    = recv_count;
                phase_next        = PH_RECV_HI;
                if (recv_count == 5'd0)
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end
        end
        else
        begin
            // Saturating tick count since transfer start
            if (cmd.tick && (elapsed_reg != '1))
            begin
                elapsed_next = elapsed_reg + 32'd1;
            end

            unique case (phase_reg)
                PH_SEND_HI:
                begin
                    if (!cmd.peer_clock)
                    begin
                        send_shift_next = send_shift_reg >> 1;
                        phase_next      = PH_SEND_LO;
                        advanced        = 1'b1;
                    end
                end
                PH_SEND_LO:
                begin
                    if (cmd.peer_clock)
                    begin
                        bits_left_next = bits_left_reg - 5'd1;
                        advanced       = 1'b1;
                        if (bits_left_reg == 5'd1)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SEND_HI;
                        end
                    end
                end
                PH_RECV_HI:
                begin
                    if (cmd.peer_clock)
                    begin
                        sampled_bit_next = cmd.peer_data;
                        phase_next       = PH_RECV_LO;
                        advanced         = 1'b1;
                    end
                end
                PH_RECV_LO:
                begin
                    if (!cmd.peer_clock)
                    begin
                        receive_acc_next[bit_position_reg] =
                            receive_acc_reg[bit_position_reg] | sampled_bit_reg;
                        bit_position_next = bit_position_reg + POS_WIDTH'(1);
                        bits_left_next    = bits_left_reg - 5'd1;
                        advanced          = 1'b1;
                        if (bits_left_reg == 5'd1)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RECV_HI;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // A peer edge that ends the wait beats the timeout
            if (!advanced && (elapsed_next > timeout_reg))
            begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                tmo        = 1'b1;
            end
        end
    end

    // Result fields follow the phase after this transfer
    always_comb
    begin
        result_next                = '0;
        result_next.drive_clock    = (phase_next == PH_SEND_HI) || (phase_next == PH_RECV_HI);
        result_next.drive_data     = (phase_next == PH_SEND_HI) && send_shift_next[0];
        result_next.busy_res       = (phase_next != PH_IDLE);
        result_next.done_res       = done;
        result_next.timed_out      = tmo;
        result_next.received_value = 16'(receive_acc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            send_shift_reg   <= '0;
            bits_left_reg    <= '0;
            receive_acc_reg  <= '0;
            bit_position_reg <= '0;
            sampled_bit_reg  <= 1'b0;
            elapsed_reg      <= '0;
        end
        else if (cmd_fire)
        begin
            phase_reg        <= phase_next;
            send_shift_reg   <= send_shift_next;
            bits_left_reg    <= bits_left_next;
            receive_acc_reg  <= receive_acc_next;
            bit_position_reg <= bit_position_next;
            sampled_bit_reg  <= sampled_bit_next;
            elapsed_reg      <= elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            out_data_reg <= result_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.drive_clock    = out_data_reg.drive_clock;
    assign res.drive_data     = out_data_reg.drive_data;
    assign res.busy_res       = out_data_reg.busy_res;
    assign res.done_res       = out_data_reg.done_res;
    assign res.timed_out      = out_data_reg.timed_out;
    assign res.received_value = out_data_reg.received_value;

    `HBLM_ASSERT_IMPL(a_tmo_is_done, res.valid && res.timed_out, res.done_res, "timeout without done")
    `HBLM_ASSERT_IMPL(a_done_not_busy, res.valid && res.done_res, !res.busy_res, "done while busy")
    `HBLM_ASSERT_NEXT(a_start_goes_busy, cmd_fire && (phase_reg == PH_IDLE) && (cmd.mode == MODE_SEND) && (cmd.bit_count != 5'd0), phase_reg == PH_SEND_HI, "send start lost")
    `HBLM_ASSERT_NEXT(a_elapsed_monotonic, cmd_fire && (phase_reg != PH_IDLE), elapsed_reg >= $past(elapsed_reg), "elapsed count went back")

endmodule

`default_nettype wire
